// ----- rtl/pcpe_pkg.sv -----
// Shared types, register codes and constants for the curve point evaluator.
package pcpe_pkg;

    // Payload field types
    typedef logic signed [23:0] t_angle;
    typedef logic signed [24:0] t_xy;
    typedef logic signed [31:0] t_pos_z;
    typedef logic        [21:0] t_slope_z;

    // Curve kind codes
    localparam logic [1:0] KIND_ELLIPSE = 2'd0;
    localparam logic [1:0] KIND_CIRCLE  = 2'd1;
    localparam logic [1:0] KIND_HELIX   = 2'd2;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_KIND  = 2'd0;
    localparam logic [1:0] REG_MAJOR = 2'd1;
    localparam logic [1:0] REG_MINOR = 2'd2;
    localparam logic [1:0] REG_PITCH = 2'd3;

    // Reset values of the radius and pitch registers (1.0 in Q16.8)
    localparam logic [23:0] RADIUS_RESET = 24'd256;

    // Fixed-point constants
    localparam logic        [30:0] TWO_PI_Q28      = 31'd1686629713;
    localparam logic        [29:0] INV_TWO_PI_Q32  = 30'd683565276;
    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
    localparam logic signed [26:0] XY_LIMIT        = 27'sd16777215;

    // Arctangent of 2^-i in Q30 radians
    function automatic logic signed [31:0] atan_q30(input int i);
        logic signed [31:0] v;
        case (i)
            0:  v = 32'sd843314856;
            1:  v = 32'sd497837829;
            2:  v = 32'sd263043836;
            3:  v = 32'sd133525158;
            4:  v = 32'sd67021686;
            5:  v = 32'sd33543515;
            6:  v = 32'sd16775850;
            7:  v = 32'sd8388437;
            8:  v = 32'sd4194282;
            9:  v = 32'sd2097149;
            10: v = 32'sd1048575;
            11: v = 32'sd524287;
            12: v = 32'sd262143;
            13: v = 32'sd131071;
            14: v = 32'sd65535;
            15: v = 32'sd32767;
            16: v = 32'sd16383;
            17: v = 32'sd8191;
            18: v = 32'sd4095;
            19: v = 32'sd2047;
            20: v = 32'sd1023;
            21: v = 32'sd511;
            22: v = 32'sd255;
            23: v = 32'sd127;
            24: v = 32'sd63;
            25: v = 32'sd31;
            26: v = 32'sd15;
            27: v = 32'sd8;
            28: v = 32'sd4;
            29: v = 32'sd2;
            30: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/pcpe_if.sv -----
// Request and result channel interfaces of the curve point evaluator.
interface pcpe_req_if import pcpe_pkg::*; ();
    logic   valid;
    logic   ready;
    t_angle angle_turns;

    modport source (output valid, output angle_turns, input ready);
    modport sink   (input valid, input angle_turns, output ready);
endinterface

interface pcpe_res_if import pcpe_pkg::*; ();
    logic     valid;
    logic     ready;
    t_xy      pos_x;
    t_xy      pos_y;
    t_pos_z   pos_z;
    t_xy      slope_x;
    t_xy      slope_y;
    t_slope_z slope_z;
    logic     config_ok;

    modport source (
        output valid, output pos_x, output pos_y, output pos_z,
        output slope_x, output slope_y, output slope_z, output config_ok,
        input ready
    );
    modport sink (
        input valid, input pos_x, input pos_y, input pos_z,
        input slope_x, input slope_y, input slope_z, input config_ok,
        output ready
    );
endinterface

// ----- rtl/parametric_curve_point_eval.sv -----
// Top level of the curve point evaluator: CORDIC pipeline, scaling and APB registers.
//
// Each request on i_req carries one angle in turns (signed Q8.16). For the
// configured curve (ellipse, circle or helix) one result on o_res returns the
// point, its derivative per radian and a flag telling whether the
// configuration is consistent. Configuration is written over the APB port
// (kind at 0x0, major radius at 0x4, minor radius at 0x8, pitch at 0xC) while
// no request is in flight; pready is always high.
// Throughput is one request per cycle unless every stage is full and the
// receiver stalls. A request passes through the input register, the
// residual angle multiply, one register per CORDIC micro-rotation stage,
// the radius multiplies and rounding and saturation into the output register.
// Every stage holds its own valid bit. When the receiver stalls, the output
// register holds its result and earlier stages keep moving into any empty
// stage, so requests are still taken until the pipeline is full.
// Reset clears all valid bits and loads the registers with ellipse kind and
// radii and pitch of 1.0.
module parametric_curve_point_eval import pcpe_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pcpe_req_if.sink           i_req,
    pcpe_res_if.source         o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [3:0]  paddr,
    input  logic        [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready
);

    localparam int LAST     = CORDIC_STAGES + 3;
    localparam int POS_PROD = CORDIC_STAGES + 2;
    localparam int NS       = CORDIC_STAGES;

    // Configuration registers
    logic [1:0]  r_kind;
    logic [23:0] r_major;
    logic [23:0] r_minor;
    logic [23:0] r_pitch;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= KIND_ELLIPSE;
            r_major <= RADIUS_RESET;
            r_minor <= RADIUS_RESET;
            r_pitch <= RADIUS_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_KIND:  r_kind  <= pwdata[1:0];
                REG_MAJOR: r_major <= pwdata[23:0];
                REG_MINOR: r_minor <= pwdata[23:0];
                REG_PITCH: r_pitch <= pwdata[23:0];
                default:   r_kind  <= r_kind;
            endcase
        end
    end

    // Register read back
    always_comb begin
        case (paddr[3:2])
            REG_KIND:  prdata = {30'd0, r_kind};
            REG_MAJOR: prdata = {8'd0, r_major};
            REG_MINOR: prdata = {8'd0, r_minor};
            REG_PITCH: prdata = {8'd0, r_pitch};
            default:   prdata = 32'd0;
        endcase
    end

    // Stage enables: a stage moves when any stage from it to the output is
    // empty, or the receiver takes the result.
    logic [LAST:0] r_v;
    logic [LAST:0] empty;
    logic [LAST:0] en;

    assign empty = ~r_v;

    always_comb begin
        for (int p = 0; p <= LAST; p++) begin
            en[p] = o_res.ready || ((empty >> p) != '0);
        end
    end

    assign i_req.ready = en[0];
    assign o_res.valid = r_v[LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_req.valid;
            end
            for (int p = 1; p <= LAST; p++) begin
                if (en[p]) begin
                    r_v[p] <= r_v[p-1];
                end
            end
        end
    end

    // Input register
    t_angle r_in_angle;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_in_angle <= i_req.angle_turns;
        end
    end

    // Residual angle of the quadrant in Q30 radians
    logic [44:0]        theta_prod;
    logic signed [31:0] theta;

    assign theta_prod = {31'd0, r_in_angle[13:0]} * {14'd0, TWO_PI_Q28};
    assign theta      = signed'({1'b0, theta_prod[44:14]});

    // CORDIC state per stage; entry k holds the state after k rotations
    logic signed [31:0] r_x    [0:NS];
    logic signed [31:0] r_y    [0:NS];
    logic signed [31:0] r_z    [0:NS];
    logic        [1:0]  r_quad [0:NS];
    t_angle             r_ang  [0:NS];
    logic signed [31:0] n_x    [0:NS-1];
    logic signed [31:0] n_y    [0:NS-1];
    logic signed [31:0] n_z    [0:NS-1];

    // One micro-rotation per stage, direction from the sign of z
    for (genvar k = 0; k < NS; k++) begin : g_rot
        assign n_x[k] = !r_z[k][31] ? r_x[k] - (r_y[k] >>> k) : r_x[k] + (r_y[k] >>> k);
        assign n_y[k] = !r_z[k][31] ? r_y[k] + (r_x[k] >>> k) : r_y[k] - (r_x[k] >>> k);
        assign n_z[k] = !r_z[k][31] ? r_z[k] - atan_q30(k) : r_z[k] + atan_q30(k);
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_x[0]    <= CORDIC_GAIN_Q30;
            r_y[0]    <= '0;
            r_z[0]    <= theta;
            r_quad[0] <= r_in_angle[15:14];
            r_ang[0]  <= r_in_angle;
        end
        for (int k = 0; k < NS; k++) begin
            if (en[k+2]) begin
                r_x[k+1]    <= n_x[k];
                r_y[k+1]    <= n_y[k];
                r_z[k+1]    <= n_z[k];
                r_quad[k+1] <= r_quad[k];
                r_ang[k+1]  <= r_ang[k];
            end
        end
    end

    // Quadrant mapping of the rotated vector into cosine and sine
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;

    always_comb begin
        case (r_quad[NS])
            2'd0: begin
                cos_v = r_x[NS];
                sin_v = r_y[NS];
            end
            2'd1: begin
                cos_v = -r_y[NS];
                sin_v = r_x[NS];
            end
            2'd2: begin
                cos_v = -r_x[NS];
                sin_v = -r_y[NS];
            end
            default: begin
                cos_v = r_y[NS];
                sin_v = -r_x[NS];
            end
        endcase
    end

    // Radius, pitch and slope products
    logic signed [24:0] rad_a;
    logic signed [24:0] rad_b;
    logic signed [24:0] pitch_s;
    logic signed [56:0] r_pac;
    logic signed [56:0] r_pbs;
    logic signed [56:0] r_pas;
    logic signed [56:0] r_pbc;
    logic signed [48:0] r_ppa;
    logic        [53:0] r_psz;

    assign rad_a   = signed'({1'b0, r_major});
    assign rad_b   = (r_kind == KIND_CIRCLE || r_kind == KIND_HELIX) ?
                     signed'({1'b0, r_major}) : signed'({1'b0, r_minor});
    assign pitch_s = signed'({1'b0, r_pitch});

    always_ff @(posedge i_clk) begin
        if (en[POS_PROD]) begin
            r_pac <= rad_a * cos_v;
            r_pbs <= rad_b * sin_v;
            r_pas <= rad_a * sin_v;
            r_pbc <= rad_b * cos_v;
            r_ppa <= pitch_s * r_ang[NS];
            r_psz <= r_pitch * INV_TWO_PI_Q32;
        end
    end

    // Round a Q38 product to Q8 and saturate to the coordinate range
    function automatic t_xy scale_xy(input logic signed [56:0] prod);
        logic signed [56:0] sum;
        logic signed [26:0] sh;
        t_xy                res;
        sum = prod + 57'sd536870912;
        sh  = sum[56:30];
        if (sh > XY_LIMIT) begin
            res = XY_LIMIT[24:0];
        end else if (sh < -XY_LIMIT) begin
            res = -XY_LIMIT[24:0];
        end else begin
            res = sh[24:0];
        end
        return res;
    endfunction

    // Helix height, rounded and saturated to 32 bits
    logic signed [48:0] pz_sum;
    logic signed [32:0] pz_sh;
    t_pos_z             pz_sat;
    logic        [53:0] sz_sum;
    logic               helix;
    logic               cfg_ok;

    assign pz_sum = r_ppa + 49'sd32768;
    assign pz_sh  = pz_sum[48:16];
    assign sz_sum = r_psz + 54'd2147483648;
    assign helix  = (r_kind == KIND_HELIX);

    always_comb begin
        if (pz_sh > 33'sd2147483647) begin
            pz_sat = 32'sh7FFFFFFF;
        end else if (pz_sh < -33'sd2147483648) begin
            pz_sat = 32'sh80000000;
        end else begin
            pz_sat = pz_sh[31:0];
        end
    end

    // Consistency of the configuration for its kind
    always_comb begin
        case (r_kind)
            KIND_ELLIPSE: cfg_ok = (r_major != '0) && (r_minor != '0);
            KIND_CIRCLE:  cfg_ok = (r_major != '0) && (r_minor == r_major);
            KIND_HELIX:   cfg_ok = (r_major != '0) && (r_pitch != '0);
            default:      cfg_ok = 1'b0;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (en[LAST]) begin
            o_res.pos_x     <= scale_xy(r_pac);
            o_res.pos_y     <= scale_xy(r_pbs);
            o_res.slope_x   <= -scale_xy(r_pas);
            o_res.slope_y   <= scale_xy(r_pbc);
            o_res.pos_z     <= helix ? pz_sat : '0;
            o_res.slope_z   <= helix ? sz_sum[53:32] : '0;
            o_res.config_ok <= cfg_ok;
        end
    end

    // The request side stalls only while every stage is full and the
    // receiver holds off.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (r_v == '1) && !o_res.ready)
        else $error("request side stalled with an empty stage");

    // Height and its slope stay zero for every kind but the helix.
    a_flat_unless_helix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !helix |-> (o_res.pos_z == '0) && (o_res.slope_z == '0))
        else $error("nonzero height outside helix mode");

    // A circle is reported as valid only with equal radii.
    a_circle_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.config_ok && (r_kind == KIND_CIRCLE) |-> r_minor == r_major)
        else $error("circle reported valid with unequal radii");

    // No result is shown in the cycle after reset.
    a_reset_clears: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_res.valid)
        else $error("result valid right after reset");

endmodule

// ----- tb/pcpe_point_checker.sv -----
// Checker for the curve point evaluator: tracks the registers, predicts each point and compares.
`timescale 1ns / 1ps

module pcpe_point_checker import pcpe_pkg::*; #(
    parameter int N_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcpe_req_if         i_req,
    pcpe_res_if         i_res,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending
);

    // Fixed-point constants of the sine/cosine and helix arithmetic
    localparam longint TURN_Q28     = 64'sd1686629713;
    localparam longint INV_TURN_Q32 = 64'sd683565276;
    localparam longint GAIN_Q30     = 64'sd652032874;
    localparam longint XY_MAX       = 64'sd16777215;
    localparam longint Z_MIN        = -64'sd2147483648;
    localparam longint Z_MAX        = 64'sd2147483647;

    // Arctangent of 2^-i in Q30 radians, one entry per micro-rotation
    localparam longint ATAN_STEP_Q30 [32] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
        127, 63, 31, 15, 8, 4, 2, 1, 0
    };

    typedef struct {
        t_xy      pos_x;
        t_xy      pos_y;
        t_pos_z   pos_z;
        t_xy      slope_x;
        t_xy      slope_y;
        t_slope_z slope_z;
        logic     config_ok;
    } t_curve_point;

    // Shadow copy of the configuration registers
    logic [1:0]  cfg_kind  = KIND_ELLIPSE;
    logic [23:0] cfg_major = 24'd256;
    logic [23:0] cfg_minor = 24'd256;
    logic [23:0] cfg_pitch = 24'd256;

    t_curve_point expected_points [$];
    int           fails = 0;

    function automatic longint clamp_to(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Radius times a Q30 sine or cosine, rounded to Q8 and saturated.
    function automatic longint scale_radius(logic [23:0] radius, longint trig);
        longint p;
        p = longint'(radius) * trig + (64'sd1 <<< 29);
        return clamp_to(p >>> 30, -XY_MAX, XY_MAX);
    endfunction

    function automatic t_curve_point eval_curve_point(t_angle angle);
        t_curve_point pt;
        longint cx, cy, cz, dx, dy, cosv, sinv, zp;
        logic [23:0] rad_b;

        // Rotation-mode CORDIC on the residual angle within the quadrant
        cx = GAIN_Q30;
        cy = 0;
        cz = (longint'(angle[13:0]) * TURN_Q28) >>> 14;
        for (int i = 0; i < N_STAGES && i < 32; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cz >= 0) begin
                cx = cx - dx;
                cy = cy + dy;
                cz = cz - ATAN_STEP_Q30[i];
            end else begin
                cx = cx + dx;
                cy = cy - dy;
                cz = cz + ATAN_STEP_Q30[i];
            end
        end

        // Map the first-quadrant pair back to the true quadrant
        case (angle[15:14])
            2'd0: begin cosv = cx;  sinv = cy;  end
            2'd1: begin cosv = -cy; sinv = cx;  end
            2'd2: begin cosv = -cx; sinv = -cy; end
            default: begin cosv = cy; sinv = -cx; end
        endcase

        // Circle and helix take the major radius on both axes.
        rad_b = (cfg_kind == KIND_CIRCLE || cfg_kind == KIND_HELIX) ? cfg_major : cfg_minor;
        pt.pos_x   = t_xy'(scale_radius(cfg_major, cosv));
        pt.pos_y   = t_xy'(scale_radius(rad_b, sinv));
        pt.slope_x = t_xy'(-scale_radius(cfg_major, sinv));
        pt.slope_y = t_xy'(scale_radius(rad_b, cosv));

        case (cfg_kind)
            KIND_ELLIPSE: pt.config_ok = (cfg_major != 0) && (cfg_minor != 0);
            KIND_CIRCLE:  pt.config_ok = (cfg_major != 0) && (cfg_minor == cfg_major);
            KIND_HELIX:   pt.config_ok = (cfg_major != 0) && (cfg_pitch != 0);
            default:      pt.config_ok = 1'b0;
        endcase

        // Helix rise: pitch times the angle in turns, and its constant rate
        pt.pos_z   = '0;
        pt.slope_z = '0;
        if (cfg_kind == KIND_HELIX) begin
            zp = longint'(cfg_pitch) * longint'(angle) + (64'sd1 <<< 15);
            pt.pos_z   = t_pos_z'(clamp_to(zp >>> 16, Z_MIN, Z_MAX));
            pt.slope_z = t_slope_z'((longint'(cfg_pitch) * INV_TURN_Q32
                                     + (64'sd1 <<< 31)) >>> 32);
        end
        return pt;
    endfunction

    task automatic compare_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    // Watch the register port and both channels on every rising clock edge.
    always @(posedge i_clk) begin
        t_curve_point want;
        if (!i_rst_n) begin
            cfg_kind  = KIND_ELLIPSE;
            cfg_major = RADIUS_RESET;
            cfg_minor = RADIUS_RESET;
            cfg_pitch = RADIUS_RESET;
            expected_points.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_KIND:  cfg_kind  = i_pwdata[1:0];
                    REG_MAJOR: cfg_major = i_pwdata[23:0];
                    REG_MINOR: cfg_minor = i_pwdata[23:0];
                    REG_PITCH: cfg_pitch = i_pwdata[23:0];
                    default: ;
                endcase
            end

            if (i_res.valid && i_res.ready) begin
                if (expected_points.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    fails++;
                end else begin
                    want = expected_points.pop_front();
                    compare_field("pos_x", want.pos_x, i_res.pos_x);
                    compare_field("pos_y", want.pos_y, i_res.pos_y);
                    compare_field("pos_z", want.pos_z, i_res.pos_z);
                    compare_field("slope_x", want.slope_x, i_res.slope_x);
                    compare_field("slope_y", want.slope_y, i_res.slope_y);
                    compare_field("slope_z", want.slope_z, i_res.slope_z);
                    compare_field("config_ok", want.config_ok, i_res.config_ok);
                end
            end

            if (i_req.valid && i_req.ready) begin
                expected_points.push_back(eval_curve_point(i_req.angle_turns));
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_points.size();
    end

endmodule

// ----- tb/tb.sv -----
// Top of the curve point evaluator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
    import pcpe_pkg::*;

    localparam int N_STAGES         = 16;
    localparam int PIPE_LATENCY     = N_STAGES + 3;
    localparam int LIMIT_CYCLES     = 200000;
    localparam int RANDOM_PHASES    = 8;
    localparam int ANGLES_PER_PHASE = 150;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    bit          calm;
    int          idle_pct;

    pcpe_req_if req_bus ();
    pcpe_res_if res_bus ();

    parametric_curve_point_eval #(
        .CORDIC_STAGES (N_STAGES)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    pcpe_point_checker #(
        .N_STAGES (N_STAGES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_bus),
        .i_res        (res_bus),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock generation
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the whole run
    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("parametric_curve_point_eval regression: fail");
        $finish;
    end

    // Result receiver: random stall bursts until the calm final phase.
    initial begin
        res_bus.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!calm && $urandom_range(0, 99) < 30) begin
                res_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // Offer one angle, with an occasional idle burst ahead of it.
    task automatic send_angle(input t_angle angle);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.angle_turns <= angle;
        do @(posedge i_clk); while (!req_bus.ready);
    endtask

    // Stop sending and wait until every outstanding point has come back.
    task automatic drain_results();
        req_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // One register write: setup cycle, then access cycle until pready.
    task automatic apb_write(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Reconfigure the curve while idle; unused upper data bits carry noise.
    task automatic load_curve(input logic [1:0] kind, input logic [23:0] major,
                              input logic [23:0] minor, input logic [23:0] pitch);
        drain_results();
        apb_write(REG_KIND, {30'($urandom()), kind});
        apb_write(REG_MAJOR, {8'($urandom()), major});
        apb_write(REG_MINOR, {8'($urandom()), minor});
        apb_write(REG_PITCH, {8'($urandom()), pitch});
    endtask

    function automatic logic [23:0] random_radius();
        case ($urandom_range(0, 9))
            0:       return 24'd0;
            1:       return 24'hFFFFFF;
            2:       return 24'($urandom_range(1, 1023));
            3:       return 24'($urandom());
            default: return 24'($urandom_range(1, 24'hFFFFF));
        endcase
    endfunction

    // Mostly uniform angles, some pinned near quadrant boundaries.
    function automatic t_angle random_angle();
        logic [13:0] residue;
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
                0:       residue = 14'h0000;
                1:       residue = 14'h0001;
                2:       residue = 14'h3FFE;
                default: residue = 14'h3FFF;
            endcase
            return {8'($urandom()), 2'($urandom()), residue};
        end
        return t_angle'($urandom());
    endfunction

    // Stimulus: directed corners, then randomly configured random phases.
    initial begin
        t_angle      corner_angles [13] = '{
            24'sh000000, 24'sh000001, 24'sh003FFF, 24'sh004000, 24'sh007FFF,
            24'sh008000, 24'sh00C000, 24'sh00FFFF, 24'sh7FFFFF, 24'sh800000,
            24'shFFFFFF, 24'sh002000, 24'sh123456
        };
        t_angle      helix_angles [6] = '{
            24'sh002000, 24'sh7FFFFF, 24'sh800000, 24'sh006000, 24'sh00E000,
            24'sh00A000
        };
        logic [1:0]  kind;
        logic [23:0] major;
        logic [23:0] minor;

        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        req_bus.valid       <= 1'b0;
        req_bus.angle_turns <= '0;
        calm                = 1'b0;
        idle_pct            = 20;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: unit ellipse over the angle corners.
        foreach (corner_angles[i]) send_angle(corner_angles[i]);

        // Helix at full radius and pitch: saturation and extreme rise.
        load_curve(KIND_HELIX, 24'hFFFFFF, 24'h000000, 24'hFFFFFF);
        foreach (helix_angles[i]) send_angle(helix_angles[i]);

        // Circle with unequal radii ignores the minor radius.
        load_curve(KIND_CIRCLE, 24'h001234, 24'h000100, 24'h000001);
        send_angle(24'sh001000);
        send_angle(24'sh00B000);
        send_angle(24'shFF4000);

        // Unused kind behaves as an ellipse and flags the setup as bad.
        load_curve(KIND_UNUSED, 24'h000000, 24'h00ABCD, 24'h000000);
        send_angle(24'sh003000);
        send_angle(24'sh010000);
        send_angle(24'sh80C000);

        // Random phases, the last one without any idling.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: kind = KIND_ELLIPSE;
                3, 4, 5: kind = KIND_CIRCLE;
                6, 7, 8: kind = KIND_HELIX;
                default: kind = KIND_UNUSED;
            endcase
            major = random_radius();
            minor = (kind == KIND_CIRCLE && $urandom_range(0, 3) != 0) ? major : random_radius();
            load_curve(kind, major, minor, random_radius());
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 15;
                default: idle_pct = 40;
            endcase
            if (p == RANDOM_PHASES - 1) begin
                calm     = 1'b1;
                idle_pct = 0;
            end
            for (int n = 0; n < ANGLES_PER_PHASE; n++) begin
                // Let the pipeline empty completely once mid-stream.
                if (p == 0 && n == ANGLES_PER_PHASE / 2) drain_results();
                send_angle(random_angle());
            end
        end

        drain_results();
        repeat (PIPE_LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("parametric_curve_point_eval regression: pass");
        end else begin
            $display("parametric_curve_point_eval regression: fail");
        end
        $finish;
    end

endmodule
